// ----- hw/rtl/sorted_index_insert_find_defines.svh -----
// ----------------------------------------------------------------------------
// Sorted index insert/find: assertion macros
// Shared assertion wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef SORTED_INDEX_INSERT_FIND_DEFINES_SVH
`define SORTED_INDEX_INSERT_FIND_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define SIF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sif assertion failed");
// Next-cycle implication, disabled during reset.
`define SIF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sif assertion failed");
`else
`define SIF_ASSERT_NOW(lbl, ante, cons)
`define SIF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/sif_pkg.sv -----
// ----------------------------------------------------------------------------
// sif_pkg
// Types and codes shared by the sorted index controller and datapath.
// ----------------------------------------------------------------------------
package sif_pkg;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_FIND   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [1:0] REL_BELOW = 2'd0;
  localparam logic [1:0] REL_EQUAL = 2'd1;
  localparam logic [1:0] REL_ABOVE = 2'd2;

  localparam logic [1:0] STS_DONE  = 2'd0;
  localparam logic [1:0] STS_EQUAL = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  element_id;
    logic [31:0] key;
  } sif_in_t;

  typedef struct packed {
    logic [8:0] position;
    logic [1:0] relation;
    logic [1:0] status;
    logic [8:0] entry_total;
  } sif_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RDID,
    ST_RDKEY,
    ST_CMP,
    ST_FIN,
    ST_SHIFT,
    ST_WRITE,
    ST_DONE
  } sif_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic set_at;
    logic shift;
    logic write_new;
    logic finish;
  } sif_cmd_t;

  typedef struct packed {
    logic is_search;
    logic range_empty;
    logic cmp_eq;
    logic cmp_stop;
    logic can_insert;
    logic shift_done;
  } sif_stat_t;

endpackage

// ----- hw/rtl/sif_ctrl.sv -----
// ----------------------------------------------------------------------------
// sif_ctrl
// Sequencer for search, shift and insert steps of the sorted index.
// ----------------------------------------------------------------------------
`include "sorted_index_insert_find_defines.svh"

module sif_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  sif_pkg::sif_stat_t stat,
  output sif_pkg::sif_cmd_t  cmd
);
  import sif_pkg::*;

  sif_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!stat.is_search) state_nxt = ST_DONE;
        else if (stat.range_empty) state_nxt = ST_FIN;
        else state_nxt = ST_RDID;
      end
      ST_RDID:  state_nxt = ST_RDKEY;
      ST_RDKEY: state_nxt = ST_CMP;
      ST_CMP: begin
        if (stat.cmp_eq || stat.cmp_stop) state_nxt = ST_FIN;
        else state_nxt = ST_RDID;
      end
      ST_FIN: begin
        if (stat.can_insert) state_nxt = ST_SHIFT;
        else state_nxt = ST_DONE;
      end
      ST_SHIFT: begin
        if (stat.shift_done) state_nxt = ST_WRITE;
      end
      ST_WRITE: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:  cmd.load = start;
      ST_CMP:   cmd.step = 1'b1;
      ST_FIN:   cmd.set_at = 1'b1;
      ST_SHIFT: cmd.shift = 1'b1;
      ST_WRITE: cmd.write_new = 1'b1;
      ST_DONE:  cmd.finish = 1'b1;
      default:  cmd = '0;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  `SIF_ASSERT_NEXT(a_done_to_idle, state_r == ST_DONE, state_r == ST_IDLE)
  `SIF_ASSERT_NEXT(a_write_to_done, state_r == ST_WRITE, state_r == ST_DONE)
  `SIF_ASSERT_NEXT(a_start_taken, start && !busy, state_r == ST_CHECK)
endmodule

// ----- hw/rtl/sif_dpath.sv -----
// ----------------------------------------------------------------------------
// sif_dpath
// Id list and key memories, search registers, shift pointer and result.
// ----------------------------------------------------------------------------
module sif_dpath #(
  parameter int CAPACITY  = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sif_pkg::sif_in_t   in_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  sif_pkg::sif_cmd_t  cmd,
  output sif_pkg::sif_stat_t stat,
  output logic               out_valid,
  output sif_pkg::sif_out_t  out_data
);
  import sif_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic [7:0]           id_mem [CAPACITY];
  logic [KEY_WIDTH-1:0] key_mem [256];

  logic [1:0]           func_r;
  logic [7:0]           id_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [CW-1:0]        low_r, high_r, mid_r, at_r, sp_r, count_r;
  logic [1:0]           rel_r;
  logic                 rd_pend_r, inserted_r, order_r, out_valid_r;
  logic [IW-1:0]        rd_addr_r;
  logic [7:0]           id_rd_r;
  logic [KEY_WIDTH-1:0] key_rd_r;
  sif_out_t             out_r;

  logic [CW-1:0]        low_n, high_n, mid_n, sp_m1, at_n;
  logic [1:0]           rel_now;
  logic                 k_lt, k_gt, search_f;
  logic [IW-1:0]        id_raddr, id_waddr;
  logic [7:0]           id_wdata;
  logic                 id_we;

  assign search_f = (func_r == FUNC_INSERT) || (func_r == FUNC_FIND);
  assign k_lt = key_r < key_rd_r;
  assign k_gt = key_r > key_rd_r;

  always_comb begin
    if (k_lt) rel_now = order_r ? REL_ABOVE : REL_BELOW;
    else if (k_gt) rel_now = order_r ? REL_BELOW : REL_ABOVE;
    else rel_now = REL_EQUAL;
  end

  assign low_n  = (rel_now == REL_ABOVE) ? mid_r : low_r;
  assign high_n = (rel_now == REL_BELOW) ? mid_r : high_r;
  assign mid_n  = low_n + ((high_n - low_n) >> 1);
  assign sp_m1  = sp_r - 1'b1;

  always_comb begin
    at_n = (rel_r == REL_BELOW) ? mid_r : mid_r + 1'b1;
    if (at_n > count_r) at_n = count_r;
  end

  assign stat.is_search   = search_f;
  assign stat.range_empty = (low_r == high_r);
  assign stat.cmp_eq      = (rel_now == REL_EQUAL);
  assign stat.cmp_stop    = (mid_n == mid_r);
  assign stat.can_insert  = (func_r == FUNC_INSERT) && (rel_r != REL_EQUAL) &&
                            (count_r < CW'(CAPACITY));
  assign stat.shift_done  = (sp_r == at_r) && !rd_pend_r;

  // Id list memory: one read and one write port.
  assign id_raddr = (cmd.shift && (sp_r > at_r)) ? sp_m1[IW-1:0] : mid_r[IW-1:0];
  assign id_we    = cmd.write_new || (cmd.shift && rd_pend_r);
  assign id_waddr = cmd.write_new ? at_r[IW-1:0] : IW'(rd_addr_r + 1'b1);
  assign id_wdata = cmd.write_new ? id_r : id_rd_r;

  always_ff @(posedge clk) begin
    if (id_we) id_mem[id_waddr] <= id_wdata;
    id_rd_r <= id_mem[id_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.write_new) key_mem[id_r] <= key_r;
    key_rd_r <= key_mem[id_rd_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      order_r     <= 1'b0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cfg_we) order_r <= cfg_wdata;
      if (cmd.load && (in_data.func == FUNC_CLEAR)) count_r <= '0;
      if (cmd.write_new) count_r <= count_r + 1'b1;
      if (cmd.set_at) rd_pend_r <= 1'b0;
      if (cmd.shift) rd_pend_r <= (sp_r > at_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r     <= in_data.func;
      id_r       <= in_data.element_id;
      key_r      <= KEY_WIDTH'(in_data.key);
      low_r      <= '0;
      high_r     <= count_r;
      mid_r      <= count_r >> 1;
      rel_r      <= REL_BELOW;
      inserted_r <= 1'b0;
    end
    if (cmd.step) begin
      rel_r <= rel_now;
      if (rel_now != REL_EQUAL) begin
        low_r  <= low_n;
        high_r <= high_n;
        mid_r  <= mid_n;
      end
    end
    if (cmd.set_at) begin
      at_r <= at_n;
      sp_r <= count_r;
    end
    if (cmd.shift && (sp_r > at_r)) begin
      sp_r      <= sp_m1;
      rd_addr_r <= sp_m1[IW-1:0];
    end
    if (cmd.write_new) inserted_r <= 1'b1;
    if (cmd.finish) begin
      out_r.position    <= inserted_r ? 9'(at_r) : (search_f ? 9'(mid_r) : 9'd0);
      out_r.relation    <= search_f ? rel_r : REL_BELOW;
      out_r.entry_total <= 9'(count_r);
      if (func_r != FUNC_INSERT) out_r.status <= STS_DONE;
      else if (rel_r == REL_EQUAL) out_r.status <= STS_EQUAL;
      else if (inserted_r) out_r.status <= STS_DONE;
      else out_r.status <= STS_FULL;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

// ----- hw/rtl/sorted_index_insert_find.sv -----
// ----------------------------------------------------------------------------
// sorted_index_insert_find
// Sorted list of element ids ordered by key, with insert, find and clear.
// ----------------------------------------------------------------------------
// An item is taken when start is high while busy is low, and exactly one
// result follows on out_data, marked by a one-cycle out_valid strobe that the
// receiver must take in that cycle. Insert and find run a binary search over
// the list; each search step reads the id at mid, then reads that id's key,
// then compares, and a search makes up to about log2 of the entry count plus
// one steps. An insert that lands then shifts the later entries up one place,
// one entry per cycle through the single write port of the id memory, so its
// time grows with the number of entries behind the new one. Clear and unused
// operation codes go from the check state straight to the done state. A new
// item may be started in the cycle in which the previous result is shown. Key
// memory is indexed by id; the id and key stores need no clearing after reset.
// ----------------------------------------------------------------------------
module sorted_index_insert_find #(
  parameter int CAPACITY  = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  sif_pkg::sif_in_t  in_data,
  output logic              out_valid,
  output sif_pkg::sif_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);
  import sif_pkg::*;

  sif_cmd_t  cmd;
  sif_stat_t stat;

  // The controller steps through search, shift and write phases.
  sif_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // The datapath holds the memories, the search window and the result.
  sif_dpath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );
endmodule
